// ===== rtl/lpe_pkg.sv =====
package lpe_pkg;

  // Fields of one input word, channel byte in the upper bits.
  typedef struct packed {
    logic [7:0] channel_byte;
    logic       frame_start;
  } in_word_t;

  typedef enum logic [2:0] {
    KIND_EXT       = 3'd0,
    KIND_BYTE      = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_BAD_MAGIC = 3'd3,
    KIND_TOO_BIG   = 3'd4,
    KIND_EXT_LONG  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    kind_t      kind;
    logic       last;
  } out_word_t;

  localparam logic [31:0] MAGIC_WORD  = 32'h0535_4454;
  localparam logic [7:0]  MAX_EXT_LEN = 8'd10;
  localparam logic [5:0]  WORD_BITS   = 6'd32;
  localparam logic [5:0]  BYTE_BITS   = 6'd8;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'hFFFF_FFFF;

endpackage

// ===== rtl/lpe_parser.sv =====
module lpe_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              step,
  input  lpe_pkg::in_word_t word,
  output logic              res_valid,
  output lpe_pkg::out_word_t res
);

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_SIZE    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_EXT     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_IDLE    = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [5:0]  bit_count, bit_count_next;
  logic [31:0] shift_word, shift_word_next;
  logic [3:0]  ext_remaining, ext_remaining_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] max_payload_bytes;

  phase_t      ph;
  logic [5:0]  bc, bc_inc;
  logic [31:0] sw, sw_shift;
  logic [3:0]  er;
  logic [31:0] br;

  always_comb begin
    // A frame start restarts the parser before this word is used.
    ph     = word.frame_start ? PH_MAGIC : phase;
    bc     = word.frame_start ? 6'd0 : bit_count;
    sw     = word.frame_start ? 32'd0 : shift_word;
    er     = word.frame_start ? 4'd0 : ext_remaining;
    br     = word.frame_start ? 32'd0 : bytes_remaining;
    bc_inc = bc + 6'd1;
    sw_shift = {sw[30:0], word.channel_byte[0]};

    phase_next           = ph;
    bit_count_next       = bc;
    shift_word_next      = sw;
    ext_remaining_next   = er;
    bytes_remaining_next = br;
    res_valid            = 1'b0;
    res.byte_value       = 8'd0;
    res.kind             = lpe_pkg::KIND_DONE;
    res.last             = 1'b0;

    if (ph == PH_PAYLOAD && br == 32'd0) begin
      phase_next = PH_IDLE;
      res_valid  = 1'b1;
      res.kind   = lpe_pkg::KIND_DONE;
      res.last   = 1'b1;
    end else if (ph != PH_IDLE) begin
      shift_word_next = sw_shift;
      bit_count_next  = bc_inc;
      case (ph)
        PH_MAGIC: begin
          if (bc_inc >= lpe_pkg::WORD_BITS) begin
            bit_count_next = 6'd0;
            if (sw_shift != lpe_pkg::MAGIC_WORD) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = lpe_pkg::KIND_BAD_MAGIC;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          if (bc_inc >= lpe_pkg::WORD_BITS) begin
            bit_count_next       = 6'd0;
            bytes_remaining_next = sw_shift;
            if (sw_shift > max_payload_bytes) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = lpe_pkg::KIND_TOO_BIG;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_EXTLEN;
            end
          end
        end
        PH_EXTLEN: begin
          if (bc_inc >= lpe_pkg::BYTE_BITS) begin
            bit_count_next = 6'd0;
            if (sw_shift[7:0] > lpe_pkg::MAX_EXT_LEN) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = lpe_pkg::KIND_EXT_LONG;
              res.last   = 1'b1;
            end else begin
              ext_remaining_next = sw_shift[3:0];
              if (sw_shift[7:0] != 8'd0) begin
                phase_next = PH_EXT;
              end else if (br == 32'd0) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res.kind   = lpe_pkg::KIND_DONE;
                res.last   = 1'b1;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
        end
        PH_EXT: begin
          if (bc_inc >= lpe_pkg::BYTE_BITS) begin
            bit_count_next     = 6'd0;
            ext_remaining_next = er - 4'd1;
            if (er == 4'd1) begin
              phase_next = PH_PAYLOAD;
            end
            res_valid      = 1'b1;
            res.byte_value = sw_shift[7:0];
            res.kind       = lpe_pkg::KIND_EXT;
          end
        end
        PH_PAYLOAD: begin
          if (bc_inc >= lpe_pkg::BYTE_BITS) begin
            bit_count_next       = 6'd0;
            bytes_remaining_next = br - 32'd1;
            res_valid            = 1'b1;
            res.byte_value       = sw_shift[7:0];
            res.kind             = lpe_pkg::KIND_BYTE;
            if (br == 32'd1) begin
              phase_next = PH_IDLE;
              res.last   = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC;
      bit_count         <= 6'd0;
      shift_word        <= 32'd0;
      ext_remaining     <= 4'd0;
      bytes_remaining   <= 32'd0;
      max_payload_bytes <= lpe_pkg::MAX_PAYLOAD_RESET;
    end else begin
      if (cfg_we) begin
        max_payload_bytes <= cfg_data;
      end
      if (step) begin
        phase           <= phase_next;
        bit_count       <= bit_count_next;
        shift_word      <= shift_word_next;
        ext_remaining   <= ext_remaining_next;
        bytes_remaining <= bytes_remaining_next;
      end
    end
  end

endmodule

// ===== rtl/lpe_out_reg.sv =====
module lpe_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  lpe_pkg::out_word_t res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output lpe_pkg::out_word_t out_data
);

  // The slot can take a new result when empty or being drained now.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/lsb_payload_extractor_unit.sv =====
// The input word is first registered in the hold register; its result is loaded
// into the output register when the parser steps on that word, which waits until
// the output register is free, and the result leaves from there.
// Throughput: one input word per cycle, sustained while the output side keeps up.
// Each word yields zero or one result, held in a single output register.
// Reset (rst, synchronous, active high) empties both word registers, returns the
// parser to the magic phase and sets max_payload_bytes to all ones.
module lsb_payload_extractor_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpe_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpe_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  // The input register holds one word. It is handed to the parser as soon
  // as the output register has room for whatever result that word causes,
  // so a fresh word may enter in the same cycle the held one is consumed.
  logic              hold_valid;
  lpe_pkg::in_word_t hold_word;
  logic              out_free;
  logic              step;
  logic              res_valid;
  lpe_pkg::out_word_t res;

  assign step      = hold_valid && out_free;
  assign in_ready  = !hold_valid || step;
  // The limit register is a plain flop, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_data;
    end
  end

  // The parser advances by at most one bit on each step and decides the result
  // word combinationally from its state and the held word.
  lpe_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (step),
    .word      (hold_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // The output register parts the two sides so that a waiting result does
  // not stop the next word from being accepted into an empty input register.
  lpe_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/lpe_checker.sv =====
module lpe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input lpe_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present straight after reset");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == lpe_pkg::KIND_DONE
      || out_data.kind == lpe_pkg::KIND_BAD_MAGIC
      || out_data.kind == lpe_pkg::KIND_TOO_BIG
      || out_data.kind == lpe_pkg::KIND_EXT_LONG)
    |-> out_data.last && out_data.byte_value == 8'd0)
    else $error("status word without last flag or with data");

  a_ext_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == lpe_pkg::KIND_EXT |-> !out_data.last)
    else $error("extension character flagged as last");

endmodule

bind lsb_payload_extractor_unit lpe_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/lpe_extract_checker.sv =====
module lpe_extract_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  lpe_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  lpe_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  typedef enum logic [2:0] {
    AT_MAGIC,
    AT_SIZE,
    AT_EXT_LEN,
    AT_EXT_CHARS,
    AT_PAYLOAD,
    AT_IDLE
  } parse_phase_t;

  parse_phase_t phase;
  logic [5:0]   bit_cnt;
  logic [31:0]  shreg;
  logic [3:0]   ext_left;
  logic [31:0]  bytes_left;
  logic [31:0]  size_limit;

  lpe_pkg::out_word_t due_words[$];
  int                 n_bad;
  int                 n_res;

  function automatic void restart_parse();
    phase      = AT_MAGIC;
    bit_cnt    = '0;
    shreg      = '0;
    ext_left   = '0;
    bytes_left = '0;
  endfunction

  // Advances the parser by one channel byte and says whether a result is due.
  function automatic bit extract_step(input lpe_pkg::in_word_t w,
                                      output lpe_pkg::out_word_t r);
    logic [7:0] ext_len;
    r = '0;
    if (w.frame_start)
      restart_parse();
    if (phase == AT_IDLE)
      return 1'b0;
    if (phase == AT_PAYLOAD && bytes_left == 0) begin
      phase  = AT_IDLE;
      r.kind = lpe_pkg::KIND_DONE;
      r.last = 1'b1;
      return 1'b1;
    end
    shreg   = {shreg[30:0], w.channel_byte[0]};
    bit_cnt = bit_cnt + 6'd1;
    case (phase)
      AT_MAGIC: begin
        if (bit_cnt < lpe_pkg::WORD_BITS)
          return 1'b0;
        bit_cnt = '0;
        if (shreg != lpe_pkg::MAGIC_WORD) begin
          phase  = AT_IDLE;
          r.kind = lpe_pkg::KIND_BAD_MAGIC;
          r.last = 1'b1;
          return 1'b1;
        end
        phase = AT_SIZE;
      end
      AT_SIZE: begin
        if (bit_cnt < lpe_pkg::WORD_BITS)
          return 1'b0;
        bit_cnt    = '0;
        bytes_left = shreg;
        if (bytes_left > size_limit) begin
          phase  = AT_IDLE;
          r.kind = lpe_pkg::KIND_TOO_BIG;
          r.last = 1'b1;
          return 1'b1;
        end
        phase = AT_EXT_LEN;
      end
      AT_EXT_LEN: begin
        if (bit_cnt < lpe_pkg::BYTE_BITS)
          return 1'b0;
        bit_cnt = '0;
        ext_len = shreg[7:0];
        if (ext_len > lpe_pkg::MAX_EXT_LEN) begin
          phase  = AT_IDLE;
          r.kind = lpe_pkg::KIND_EXT_LONG;
          r.last = 1'b1;
          return 1'b1;
        end
        ext_left = ext_len[3:0];
        if (ext_len != 8'd0)
          phase = AT_EXT_CHARS;
        else if (bytes_left == 0) begin
          phase  = AT_IDLE;
          r.kind = lpe_pkg::KIND_DONE;
          r.last = 1'b1;
          return 1'b1;
        end else
          phase = AT_PAYLOAD;
      end
      AT_EXT_CHARS: begin
        if (bit_cnt < lpe_pkg::BYTE_BITS)
          return 1'b0;
        bit_cnt  = '0;
        ext_left = ext_left - 4'd1;
        if (ext_left == 0)
          phase = AT_PAYLOAD;
        r.byte_value = shreg[7:0];
        r.kind       = lpe_pkg::KIND_EXT;
        return 1'b1;
      end
      default: begin
        if (bit_cnt < lpe_pkg::BYTE_BITS)
          return 1'b0;
        bit_cnt      = '0;
        bytes_left   = bytes_left - 32'd1;
        r.byte_value = shreg[7:0];
        r.kind       = lpe_pkg::KIND_BYTE;
        if (bytes_left == 0) begin
          phase  = AT_IDLE;
          r.last = 1'b1;
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void report(input string what, input lpe_pkg::out_word_t want,
                                 input lpe_pkg::out_word_t got);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t %s: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
               $time, what, want.byte_value, want.kind, want.last,
               got.byte_value, got.kind, got.last);
  endfunction

  // Results are retired before new words are predicted, so a result can never
  // be matched against an expectation raised at the same edge.
  always @(posedge clk) begin : watch
    lpe_pkg::out_word_t want;
    lpe_pkg::out_word_t got;
    if (rst) begin
      size_limit = lpe_pkg::MAX_PAYLOAD_RESET;
      restart_parse();
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        size_limit = cfg_data;
      if (out_valid && out_ready) begin
        got = out_data;
        n_res++;
        if (due_words.size() == 0)
          report("result with nothing expected", '0, got);
        else begin
          want = due_words.pop_front();
          if (got.byte_value !== want.byte_value || got.kind !== want.kind ||
              got.last !== want.last)
            report("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready)
        if (extract_step(in_data, want))
          due_words.push_back(want);
    end
    fail_count   <= n_bad;
    pending      <= due_words.size();
    results_seen <= n_res;
  end

endmodule

// ===== sim/tb.sv =====
module tb;

  // A stall of this many cycles with no word moving on any channel means the
  // block has hung; even the heaviest idling settings stay far below it.
  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  lpe_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lpe_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;

  int fail_count;
  int pending;
  int results_seen;

  // Idling odds in percent for the sender and the receiver.
  int send_gap_pct   = 19;
  int recv_stall_pct = 74;

  // Words still to be offered, the limit now in the block, and a count of
  // words taken during the random part.
  lpe_pkg::in_word_t word_q[$];
  logic [31:0]       max_bytes = lpe_pkg::MAX_PAYLOAD_RESET;
  int                rnd_sent;
  int                stall_cycles;

  lsb_payload_extractor_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lpe_extract_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh at every edge whether it will take a word.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // The watchdog restarts whenever a word moves on any of the three channels.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Queues n hidden bits of v, most significant first. Every bit rides in
  // bit 0 of its own channel byte, with random cover in the upper seven bits.
  // The frame start flag, if asked for, goes on the first of them.
  function automatic void put_bits(input logic [31:0] v, input int n, input bit start);
    lpe_pkg::in_word_t w;
    for (int i = n - 1; i >= 0; i--) begin
      w.channel_byte = {7'($urandom), v[i]};
      w.frame_start  = start && (i == n - 1);
      word_q.push_back(w);
    end
  endfunction

  function automatic void put_header(input logic [31:0] magic, input logic [31:0] size,
                                     input logic [7:0] ext_len, input bit start);
    put_bits(magic, 32, start);
    put_bits(size, 32, 1'b0);
    put_bits({24'd0, ext_len}, 8, 1'b0);
  endfunction

  function automatic void put_bytes(input int n);
    repeat (n) put_bits($urandom, 8, 1'b0);
  endfunction

  // Raw channel bytes; the odd one may carry a frame start, which throws the
  // parser into a frame made of rubbish.
  function automatic void put_noise(input int n, input int start_pct);
    lpe_pkg::in_word_t w;
    repeat (n) begin
      w.channel_byte = 8'($urandom);
      w.frame_start  = ($urandom_range(0, 99) < start_pct);
      word_q.push_back(w);
    end
  endfunction

  // One random frame. Most are well formed with random content, so that the
  // extension characters and payload bytes are reached; the rest break the
  // frame in each of the ways the parser guards against, cut it short so the
  // next frame start lands mid-field, or are plain noise.
  function automatic void put_random_frame();
    int          pick;
    logic [31:0] cap;
    logic [31:0] size;
    logic [31:0] flip;
    logic [7:0]  ext_len;
    int          keep;
    pick    = $urandom_range(0, 99);
    cap     = (max_bytes < 32'd6) ? max_bytes : 32'd6;
    size    = $urandom_range(0, cap);
    ext_len = ($urandom_range(0, 99) < 40) ? 8'd0 : 8'($urandom_range(1, 10));
    if (pick < 62) begin
      put_header(lpe_pkg::MAGIC_WORD, size, ext_len, 1'b1);
      put_bytes(ext_len);
      put_bytes(size);
      // An empty payload after extension characters needs one more byte to
      // give its done result.
      if (size == 0 && ext_len != 0)
        put_bytes(1);
    end else if (pick < 70) begin
      flip = $urandom;
      if (flip == 0)
        flip = 32'd1;
      put_bits(lpe_pkg::MAGIC_WORD ^ flip, 32, 1'b1);
    end else if (pick < 78 && max_bytes != lpe_pkg::MAX_PAYLOAD_RESET) begin
      // Just over the limit, or anywhere above it up to all ones.
      if ($urandom_range(0, 1) == 0)
        size = max_bytes + 32'd1;
      else
        size = max_bytes + 32'd1 + ($urandom % ~max_bytes);
      put_header(lpe_pkg::MAGIC_WORD, size, ext_len, 1'b1);
    end else if (pick < 86) begin
      put_header(lpe_pkg::MAGIC_WORD, size, 8'($urandom_range(11, 255)), 1'b1);
    end else if (pick < 94) begin
      keep = $urandom_range(1, 31);
      put_bits(lpe_pkg::MAGIC_WORD, 32, 1'b1);
      if ($urandom_range(0, 1) == 0)
        put_bits(lpe_pkg::MAGIC_WORD >> (32 - keep), keep, 1'b1);
      else begin
        put_bits(size, 32, 1'b0);
        put_bits({24'd0, ext_len}, 8, 1'b0);
        put_bits($urandom, keep % 8 + (ext_len != 0 ? 8 : 0), 1'b0);
      end
    end else begin
      put_noise($urandom_range(1, 40), 10);
    end
    put_noise($urandom_range(0, 2), 0);
  endfunction

  // Offers one word. Valid is only dropped when the sender chooses to idle,
  // so a word that follows straight on keeps valid high across the edge.
  task automatic send_word(input lpe_pkg::in_word_t w);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    rnd_sent++;
  endtask

  task automatic send_queued();
    while (word_q.size() > 0)
      send_word(word_q.pop_front());
  endtask

  // Holds the sender back until every predicted result has come out, then
  // waits on for words still inside the block that give no result. The
  // checker's count is registered, hence the edge before the first look.
  task automatic drain();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Only ever called with the block drained.
  task automatic write_limit(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    max_bytes = v;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed frames, with the limit still at its reset value of all ones.
    // The first frame has no frame start: parsing must begin at the magic
    // word all the same. Its payload is an all-zeros and an all-ones byte,
    // and the bytes after it must be ignored.
    put_header(lpe_pkg::MAGIC_WORD, 32'd2, 8'd0, 1'b0);
    put_bits(32'h00, 8, 1'b0);
    put_bits(32'hFF, 8, 1'b0);
    put_noise(2, 0);
    // A size of all ones equals the limit and is accepted; the frame is then
    // cut short by a new frame start in the middle of the payload.
    put_header(lpe_pkg::MAGIC_WORD, lpe_pkg::MAX_PAYLOAD_RESET, 8'd0, 1'b1);
    put_bytes(1);
    put_bits(32'h5, 3, 1'b0);
    // Bad magic, with only its lowest bit wrong.
    put_bits(lpe_pkg::MAGIC_WORD ^ 32'd1, 32, 1'b1);
    // Empty payload, no extension: done on the extension length byte.
    put_header(lpe_pkg::MAGIC_WORD, 32'd0, 8'd0, 1'b1);
    put_noise(1, 0);
    // Empty payload behind the longest allowed extension: ten characters,
    // the extremes among them, then one more byte for the done result.
    put_header(lpe_pkg::MAGIC_WORD, 32'd0, 8'd10, 1'b1);
    put_bits(32'h00, 8, 1'b0);
    put_bits(32'hFF, 8, 1'b0);
    put_bytes(9);
    // Extension length just over the limit.
    put_header(lpe_pkg::MAGIC_WORD, 32'd1, 8'd11, 1'b1);
    send_queued();
    drain();

    // Random part in three idling settings, each with its own limit. A limit
    // of zero lets only empty payloads through and turns away a single byte.
    rnd_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct   = 19;
          recv_stall_pct = 74;
          write_limit(lpe_pkg::MAX_PAYLOAD_RESET);
        end
        1: begin
          send_gap_pct   = 74;
          recv_stall_pct = 19;
          write_limit(32'd0);
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          write_limit($urandom_range(2, 1000));
        end
      endcase
      while (rnd_sent < 80 * (ph + 1) || (ph == 2 && results_seen < 32)) begin
        put_random_frame();
        send_queued();
        // Now and then the sender waits for the output side to empty.
        if ($urandom_range(0, 9) == 0)
          drain();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
